@@ hw/rtl/pawwd_pkg.sv @@
// shared constants, register indexes and state types of the progress-aware wait watchdog
package pawwd_pkg;

    localparam int CFG_BITS     = 32;
    localparam int CFG_IDX_BITS = 3;
    localparam int MIN_BITS     = 25;
    localparam int PCT_BITS     = 16;
    localparam int MIN_REM_BITS = 16;
    localparam int SCALE_BITS   = 10;

    localparam logic [MIN_REM_BITS:0] MIN_MS    = 17'd60000;
    localparam logic [SCALE_BITS-1:0] PCT_SCALE = 10'd1000;

    localparam logic [CFG_BITS-1:0] FIRST_NOTE_RST     = 32'd900000;
    localparam logic [CFG_BITS-1:0] REPEAT_NOTE_RST    = 32'd1800000;
    localparam logic [CFG_BITS-1:0] ETA_SAMPLE_RST     = 32'd300000;
    localparam logic [CFG_BITS-1:0] OVERDUE_SLACK_RST  = 32'd3600000;
    localparam logic [CFG_BITS-1:0] OVERDUE_REPEAT_RST = 32'd3600000;
    localparam logic [CFG_BITS-1:0] STALL_RST          = 32'd1800000;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_FIRST_NOTE     = 3'd0,
        CFG_REPEAT_NOTE    = 3'd1,
        CFG_ETA_SAMPLE     = 3'd2,
        CFG_OVERDUE_SLACK  = 3'd3,
        CFG_OVERDUE_REPEAT = 3'd4,
        CFG_STALL          = 3'd5
    } cfg_idx_t;

    typedef enum logic [2:0] {
        MD_IDLE = 3'b001,
        MD_MUL  = 3'b010,
        MD_DIV  = 3'b100
    } md_state_t;

    typedef enum logic [1:0] {
        MN_IDLE = 2'b01,
        MN_RUN  = 2'b10
    } mn_state_t;

    typedef enum logic [10:0] {
        ST_IDLE     = 11'b00000000001,
        ST_CLEAR    = 11'b00000000010,
        ST_TRACK    = 11'b00000000100,
        ST_DIFF     = 11'b00000001000,
        ST_START    = 11'b00000010000,
        ST_WAIT_MD  = 11'b00000100000,
        ST_PREDICT  = 11'b00001000000,
        ST_OVERDUE  = 11'b00010000000,
        ST_OVCHK    = 11'b00100000000,
        ST_WAIT_MIN = 11'b01000000000,
        ST_OUT      = 11'b10000000000
    } wd_state_t;

endpackage

@@ hw/rtl/pawwd_minutes.sv @@
// bit-serial divide by 60000 with a saturating minutes result
module pawwd_minutes #(
    parameter int T_BITS = 40
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [T_BITS-1:0]             value,
    output logic                          done,
    output logic [pawwd_pkg::MIN_BITS-1:0] minutes
);
    import pawwd_pkg::*;

    localparam int CW = $clog2(T_BITS);

    mn_state_t               state_reg;
    logic [CW-1:0]           cnt_reg;
    logic                    done_reg;
    logic [T_BITS-1:0]       val_reg;
    logic [MIN_REM_BITS-1:0] rem_reg;
    logic [MIN_BITS-1:0]     q_reg;
    logic                    ovf_reg;
    logic [MIN_REM_BITS:0]   rem_shift;
    logic [MIN_REM_BITS:0]   rem_diff;
    logic                    rem_ge;

    assign rem_shift = {rem_reg, val_reg[T_BITS-1]};
    assign rem_diff  = rem_shift - MIN_MS;
    assign rem_ge    = rem_shift >= MIN_MS;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= MN_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                MN_IDLE:
                begin
                    if (start)
                    begin
                        state_reg <= MN_RUN;
                        cnt_reg   <= '0;
                    end
                end
                MN_RUN:
                begin
                    if (cnt_reg == CW'(T_BITS - 1))
                    begin
                        state_reg <= MN_IDLE;
                        done_reg  <= 1'b1;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                end
                default:
                begin
                    state_reg <= MN_IDLE;
                end
            endcase
        end
    end

    // one quotient bit per cycle, msb first
    always_ff @(posedge clk)
    begin
        if (state_reg == MN_IDLE && start)
        begin
            val_reg <= value;
            rem_reg <= '0;
            q_reg   <= '0;
            ovf_reg <= 1'b0;
        end
        else if (state_reg == MN_RUN)
        begin
            val_reg <= {val_reg[T_BITS-2:0], 1'b0};
            rem_reg <= rem_ge ? rem_diff[MIN_REM_BITS-1:0] : rem_shift[MIN_REM_BITS-1:0];
            q_reg   <= {q_reg[MIN_BITS-2:0], rem_ge};
            ovf_reg <= ovf_reg | q_reg[MIN_BITS-1];
        end
    end

    assign done    = done_reg;
    assign minutes = ovf_reg ? '1 : q_reg;

endmodule

@@ hw/rtl/pawwd_muldiv.sv @@
// bit-serial shift-add multiply followed by restoring divide, saturating quotient
module pawwd_muldiv #(
    parameter int A_BITS = 40,
    parameter int B_BITS = 40,
    parameter int Q_BITS = 40
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [A_BITS-1:0] a,
    input  logic [B_BITS-1:0] b,
    input  logic [A_BITS-1:0] d,
    output logic              done,
    output logic [Q_BITS-1:0] q
);
    import pawwd_pkg::*;

    localparam int PW = A_BITS + B_BITS;
    localparam int CW = $clog2(PW);

    md_state_t         state_reg;
    logic [CW-1:0]     cnt_reg;
    logic              done_reg;
    logic [A_BITS-1:0] a_reg;
    logic [A_BITS-1:0] d_reg;
    logic [A_BITS-1:0] rem_reg;
    logic [PW-1:0]     prod_reg;
    logic [Q_BITS-1:0] q_reg;
    logic              ovf_reg;
    logic [A_BITS:0]   acc_sum;
    logic [A_BITS:0]   rem_shift;
    logic [A_BITS:0]   rem_diff;
    logic              rem_ge;

    assign acc_sum   = {1'b0, prod_reg[PW-1:B_BITS]} + {1'b0, a_reg};
    assign rem_shift = {rem_reg, prod_reg[PW-1]};
    assign rem_diff  = rem_shift - {1'b0, d_reg};
    assign rem_ge    = rem_shift >= {1'b0, d_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= MD_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                MD_IDLE:
                begin
                    if (start)
                    begin
                        state_reg <= MD_MUL;
                        cnt_reg   <= '0;
                    end
                end
                MD_MUL:
                begin
                    if (cnt_reg == CW'(B_BITS - 1))
                    begin
                        state_reg <= MD_DIV;
                        cnt_reg   <= '0;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                end
                MD_DIV:
                begin
                    if (cnt_reg == CW'(PW - 1))
                    begin
                        state_reg <= MD_IDLE;
                        done_reg  <= 1'b1;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                end
                default:
                begin
                    state_reg <= MD_IDLE;
                end
            endcase
        end
    end

    // multiplier bits leave at the bottom while the product grows in at the top,
    // then the product shifts out msb first into the remainder
    always_ff @(posedge clk)
    begin
        if (state_reg == MD_IDLE && start)
        begin
            a_reg    <= a;
            d_reg    <= d;
            prod_reg <= {{A_BITS{1'b0}}, b};
            rem_reg  <= '0;
            q_reg    <= '0;
            ovf_reg  <= 1'b0;
        end
        else if (state_reg == MD_MUL)
        begin
            prod_reg <= prod_reg[0] ? {acc_sum, prod_reg[B_BITS-1:1]}
                                    : {1'b0, prod_reg[PW-1:1]};
        end
        else if (state_reg == MD_DIV)
        begin
            prod_reg <= {prod_reg[PW-2:0], 1'b0};
            rem_reg  <= rem_ge ? rem_diff[A_BITS-1:0] : rem_shift[A_BITS-1:0];
            q_reg    <= {q_reg[Q_BITS-2:0], rem_ge};
            ovf_reg  <= ovf_reg | q_reg[Q_BITS-1];
        end
    end

    assign done = done_reg;
    assign q    = ovf_reg ? '1 : q_reg;

endmodule

@@ hw/rtl/progress_aware_wait_watchdog_unit.sv @@
// Progress-aware wait watchdog: one result transaction per wait-slice transaction.
//
// Input channel (in_valid/in_stall) carries one timed-out wait slice: elapsed time,
// a new_wait flag and an optional done/total progress pair. Output channel
// (out_valid/out_stall) returns the time-only, stall and overdue notes with elapsed,
// stalled and predicted minutes and the done ratio in tenths of a percent.
// Registers are written through cfg_we/cfg_index/cfg_data. The user must write them
// only while the block is idle; the block itself does not enforce it.
//
// One transaction is handled at a time: the bit-serial multiply-divide of the
// prediction and the done ratio runs first, then the serial divide by 60000 of
// the predicted total. The next transaction is accepted as soon as the result
// has moved into the output register, while it still waits there.
//
// Reset loads the register defaults and clears all tracking state; no clearing
// pass is needed. When the receiver stalls, the result holds on the output; a
// finished second result then waits inside and in_stall stays high.
module progress_aware_wait_watchdog_unit #(
    parameter int TIME_BITS  = 40,
    parameter int COUNT_BITS = 40
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [pawwd_pkg::CFG_IDX_BITS-1:0] cfg_index,
    input  logic [pawwd_pkg::CFG_BITS-1:0]     cfg_data,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic                              new_wait,
    input  logic [TIME_BITS-1:0]              elapsed_ms,
    input  logic                              probe_valid,
    input  logic [COUNT_BITS-1:0]             done_count,
    input  logic [COUNT_BITS-1:0]             total_count,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic                              time_only_note,
    output logic                              stall_note,
    output logic                              overdue_note,
    output logic [pawwd_pkg::MIN_BITS-1:0]     elapsed_minutes,
    output logic [pawwd_pkg::MIN_BITS-1:0]     stalled_minutes,
    output logic [pawwd_pkg::MIN_BITS-1:0]     predicted_minutes,
    output logic [pawwd_pkg::PCT_BITS-1:0]     percent_tenths
);
    import pawwd_pkg::*;

    function automatic logic [TIME_BITS-1:0] sat_add(input logic [TIME_BITS-1:0] x,
                                                     input logic [TIME_BITS-1:0] y);
        logic [TIME_BITS:0] s;
        s = {1'b0, x} + {1'b0, y};
        sat_add = s[TIME_BITS] ? '1 : s[TIME_BITS-1:0];
    endfunction

    function automatic logic [TIME_BITS-1:0] sat_sub(input logic [TIME_BITS-1:0] x,
                                                     input logic [TIME_BITS-1:0] y);
        sat_sub = (x >= y) ? x - y : '0;
    endfunction

    wd_state_t state_reg;
    wd_state_t state_next;

    // configuration registers
    logic [CFG_BITS-1:0] first_note_reg;
    logic [CFG_BITS-1:0] repeat_note_reg;
    logic [CFG_BITS-1:0] eta_sample_reg;
    logic [CFG_BITS-1:0] overdue_slack_reg;
    logic [CFG_BITS-1:0] overdue_repeat_reg;
    logic [CFG_BITS-1:0] stall_ms_reg;

    // captured transaction
    logic                  new_wait_reg;
    logic [TIME_BITS-1:0]  elapsed_reg;
    logic                  probed_reg;
    logic [COUNT_BITS-1:0] done_reg;
    logic [COUNT_BITS-1:0] total_reg;

    // tracking state
    logic                  seen_reg;
    logic [COUNT_BITS-1:0] base_done_reg;
    logic [TIME_BITS-1:0]  base_time_reg;
    logic [COUNT_BITS-1:0] prev_done_reg;
    logic [TIME_BITS-1:0]  last_move_reg;
    logic [TIME_BITS-1:0]  pred_reg;
    logic [TIME_BITS-1:0]  next_over_reg;
    logic [TIME_BITS-1:0]  next_stall_reg;
    logic [TIME_BITS-1:0]  next_note_reg;

    // per-transaction work
    logic [TIME_BITS-1:0]  still_reg;
    logic [TIME_BITS-1:0]  span_reg;
    logic [COUNT_BITS-1:0] left_reg;
    logic [COUNT_BITS-1:0] gain_reg;
    logic                  need_eta_reg;
    logic                  rem_ok_reg;
    logic [TIME_BITS-1:0]  od_lim_reg;
    logic [PCT_BITS-1:0]   pct_reg;
    logic                  t_note_reg;
    logic                  s_note_reg;
    logic                  o_note_reg;

    // output register
    logic                  out_valid_reg;
    logic                  t_out_reg;
    logic                  s_out_reg;
    logic                  o_out_reg;
    logic [MIN_BITS-1:0]   emin_out_reg;
    logic [MIN_BITS-1:0]   smin_out_reg;
    logic [MIN_BITS-1:0]   pmin_out_reg;
    logic [PCT_BITS-1:0]   pct_out_reg;

    logic                  in_take;
    logic                  out_load;
    logic                  md_start;
    logic                  pmin_start;
    logic                  pct_done;
    logic                  eta_done;
    logic [TIME_BITS-1:0]  pct_q;
    logic [TIME_BITS-1:0]  eta_q;
    logic                  emin_done;
    logic                  smin_done;
    logic                  pmin_done;
    logic [MIN_BITS-1:0]   emin_q;
    logic [MIN_BITS-1:0]   smin_q;
    logic [MIN_BITS-1:0]   pmin_q;
    logic [TIME_BITS-1:0]  remaining;

    assign in_stall   = (state_reg != ST_IDLE);
    assign in_take    = in_valid && (state_reg == ST_IDLE);
    assign out_load   = (state_reg == ST_OUT) && (!out_valid_reg || !out_stall);
    assign md_start   = (state_reg == ST_START);
    assign pmin_start = (state_reg == ST_OVERDUE);
    assign remaining  = rem_ok_reg ? eta_q : '0;

    pawwd_muldiv #(
        .A_BITS(COUNT_BITS),
        .B_BITS(TIME_BITS),
        .Q_BITS(TIME_BITS)
    ) u_pct_muldiv (
        .clk   (clk),
        .rst_n (rst_n),
        .start (md_start),
        .a     (done_reg),
        .b     (TIME_BITS'(PCT_SCALE)),
        .d     (total_reg),
        .done  (pct_done),
        .q     (pct_q)
    );

    pawwd_muldiv #(
        .A_BITS(COUNT_BITS),
        .B_BITS(TIME_BITS),
        .Q_BITS(TIME_BITS)
    ) u_eta_muldiv (
        .clk   (clk),
        .rst_n (rst_n),
        .start (md_start),
        .a     (left_reg),
        .b     (span_reg),
        .d     (gain_reg),
        .done  (eta_done),
        .q     (eta_q)
    );

    pawwd_minutes #(
        .T_BITS(TIME_BITS)
    ) u_elapsed_min (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (md_start),
        .value   (elapsed_reg),
        .done    (emin_done),
        .minutes (emin_q)
    );

    pawwd_minutes #(
        .T_BITS(TIME_BITS)
    ) u_stalled_min (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (md_start),
        .value   (still_reg),
        .done    (smin_done),
        .minutes (smin_q)
    );

    pawwd_minutes #(
        .T_BITS(TIME_BITS)
    ) u_predicted_min (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (pmin_start),
        .value   (pred_reg),
        .done    (pmin_done),
        .minutes (pmin_q)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:     if (in_valid) state_next = ST_CLEAR;
            ST_CLEAR:    state_next = ST_TRACK;
            ST_TRACK:    state_next = ST_DIFF;
            ST_DIFF:     state_next = ST_START;
            ST_START:    state_next = ST_WAIT_MD;
            ST_WAIT_MD:  if (pct_done && eta_done) state_next = ST_PREDICT;
            ST_PREDICT:  state_next = ST_OVERDUE;
            ST_OVERDUE:  state_next = ST_OVCHK;
            ST_OVCHK:    state_next = ST_WAIT_MIN;
            ST_WAIT_MIN: if (pmin_done) state_next = ST_OUT;
            ST_OUT:      if (out_load) state_next = ST_IDLE;
            default:     state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_note_reg     <= FIRST_NOTE_RST;
            repeat_note_reg    <= REPEAT_NOTE_RST;
            eta_sample_reg     <= ETA_SAMPLE_RST;
            overdue_slack_reg  <= OVERDUE_SLACK_RST;
            overdue_repeat_reg <= OVERDUE_REPEAT_RST;
            stall_ms_reg       <= STALL_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_FIRST_NOTE:     first_note_reg     <= cfg_data;
                CFG_REPEAT_NOTE:    repeat_note_reg    <= cfg_data;
                CFG_ETA_SAMPLE:     eta_sample_reg     <= cfg_data;
                CFG_OVERDUE_SLACK:  overdue_slack_reg  <= cfg_data;
                CFG_OVERDUE_REPEAT: overdue_repeat_reg <= cfg_data;
                CFG_STALL:          stall_ms_reg       <= cfg_data;
                default:            ;
            endcase
        end
    end

    // capture of the input transaction
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            new_wait_reg <= new_wait;
            elapsed_reg  <= elapsed_ms;
            probed_reg   <= probe_valid && (total_count != '0);
            done_reg     <= done_count;
            total_reg    <= total_count;
        end
    end

    // tracking state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg       <= 1'b0;
            base_done_reg  <= '0;
            base_time_reg  <= '0;
            prev_done_reg  <= '0;
            last_move_reg  <= '0;
            pred_reg       <= '0;
            next_over_reg  <= '0;
            next_stall_reg <= TIME_BITS'(STALL_RST);
            next_note_reg  <= TIME_BITS'(FIRST_NOTE_RST);
        end
        else
        begin
            case (state_reg)
                ST_CLEAR:
                begin
                    if (new_wait_reg)
                    begin
                        seen_reg       <= 1'b0;
                        base_done_reg  <= '0;
                        base_time_reg  <= '0;
                        prev_done_reg  <= '0;
                        last_move_reg  <= '0;
                        pred_reg       <= '0;
                        next_over_reg  <= '0;
                        next_stall_reg <= TIME_BITS'(stall_ms_reg);
                        next_note_reg  <= TIME_BITS'(first_note_reg);
                    end
                end
                ST_TRACK:
                begin
                    if (!probed_reg)
                    begin
                        if (elapsed_reg >= next_note_reg)
                        begin
                            next_note_reg <= sat_add(elapsed_reg, TIME_BITS'(repeat_note_reg));
                        end
                    end
                    else
                    begin
                        // progress went backwards or first seen: restart measuring
                        if (!seen_reg || done_reg < prev_done_reg)
                        begin
                            seen_reg      <= 1'b1;
                            base_done_reg <= done_reg;
                            base_time_reg <= elapsed_reg;
                            last_move_reg <= elapsed_reg;
                            pred_reg      <= '0;
                            next_over_reg <= '0;
                        end
                        else if (done_reg != prev_done_reg)
                        begin
                            last_move_reg <= elapsed_reg;
                        end
                        prev_done_reg <= done_reg;
                    end
                end
                ST_START:
                begin
                    if (probed_reg && still_reg >= TIME_BITS'(stall_ms_reg)
                        && elapsed_reg >= next_stall_reg)
                    begin
                        next_stall_reg <= sat_add(elapsed_reg, TIME_BITS'(stall_ms_reg));
                    end
                end
                ST_PREDICT:
                begin
                    if (probed_reg && need_eta_reg)
                    begin
                        pred_reg <= sat_add(elapsed_reg, remaining);
                    end
                end
                ST_OVCHK:
                begin
                    if (probed_reg && pred_reg != '0 && elapsed_reg >= od_lim_reg
                        && (next_over_reg == '0 || elapsed_reg >= next_over_reg))
                    begin
                        next_over_reg <= sat_add(elapsed_reg, TIME_BITS'(overdue_repeat_reg));
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // per-transaction working values
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_CLEAR:
            begin
                t_note_reg <= 1'b0;
                s_note_reg <= 1'b0;
                o_note_reg <= 1'b0;
            end
            ST_TRACK:
            begin
                if (!probed_reg && elapsed_reg >= next_note_reg)
                begin
                    t_note_reg <= 1'b1;
                end
            end
            ST_DIFF:
            begin
                still_reg <= sat_sub(elapsed_reg, last_move_reg);
                span_reg  <= sat_sub(elapsed_reg, base_time_reg);
                left_reg  <= total_reg - done_reg;
                gain_reg  <= done_reg - base_done_reg;
            end
            ST_START:
            begin
                need_eta_reg <= (pred_reg == '0) && (span_reg >= TIME_BITS'(eta_sample_reg))
                                && (done_reg > base_done_reg);
                rem_ok_reg   <= (total_reg > done_reg) && (span_reg != '0);
                if (probed_reg && still_reg >= TIME_BITS'(stall_ms_reg)
                    && elapsed_reg >= next_stall_reg)
                begin
                    s_note_reg <= 1'b1;
                end
            end
            ST_PREDICT:
            begin
                pct_reg <= (pct_q[TIME_BITS-1:PCT_BITS] != '0) ? '1 : pct_q[PCT_BITS-1:0];
            end
            ST_OVERDUE:
            begin
                od_lim_reg <= sat_add(pred_reg, TIME_BITS'(overdue_slack_reg));
            end
            ST_OVCHK:
            begin
                if (probed_reg && pred_reg != '0 && elapsed_reg >= od_lim_reg
                    && (next_over_reg == '0 || elapsed_reg >= next_over_reg))
                begin
                    o_note_reg <= 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            t_out_reg    <= t_note_reg;
            s_out_reg    <= s_note_reg;
            o_out_reg    <= o_note_reg;
            emin_out_reg <= emin_q;
            smin_out_reg <= probed_reg ? smin_q : '0;
            pmin_out_reg <= pmin_q;
            pct_out_reg  <= probed_reg ? pct_reg : '0;
        end
    end

    assign out_valid         = out_valid_reg;
    assign time_only_note    = t_out_reg;
    assign stall_note        = s_out_reg;
    assign overdue_note      = o_out_reg;
    assign elapsed_minutes   = emin_out_reg;
    assign stalled_minutes   = smin_out_reg;
    assign predicted_minutes = pmin_out_reg;
    assign percent_tenths    = pct_out_reg;

`ifndef SYNTHESIS
    // an accepted transaction always starts its processing sequence
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> state_reg == ST_CLEAR)
        else $error("accepted transaction did not start processing");

    // a result only appears from the final sequencer step
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(state_reg == ST_OUT))
        else $error("result appeared outside the output step");

    // the time-only note excludes the progress notes
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(time_only_note && (stall_note || overdue_note)))
        else $error("time-only note together with a progress note");

    // both multiply-divide units run in lockstep
    assert property (@(posedge clk) disable iff (!rst_n)
        pct_done == eta_done)
        else $error("multiply-divide units out of step");
`endif

endmodule

@@ dv/progress_aware_wait_watchdog_unit_tb.sv @@
// self-checking testbench of the progress-aware wait watchdog unit
module progress_aware_wait_watchdog_unit_tb;
    import pawwd_pkg::*;

    localparam int TIME_W = 40;
    localparam int COUNT_W = 40;
    localparam logic [TIME_W-1:0] T_MAX = '1;
    localparam logic [COUNT_W-1:0] C_MAX = '1;
    localparam logic [63:0] TIME_CEIL = 64'h0000_00FF_FFFF_FFFF;
    localparam logic [MIN_BITS-1:0] MIN_CEIL = '1;
    localparam logic [PCT_BITS-1:0] PCT_CEIL = '1;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int DRAIN_CYCLES = 400;
    localparam int IDLE_PCT = 13;
    localparam int ITEMS_PER_PHASE = 158;
    localparam int MAX_REPORTS = 200;

    typedef enum int {
        SET_ZERO,
        SET_MAX,
        SET_SMALL,
        SET_RANDOM,
        SET_DEFAULT
    } cfg_mode_t;

    typedef struct packed {
        logic               new_wait;
        logic [TIME_W-1:0]  elapsed;
        logic               probe;
        logic [COUNT_W-1:0] done;
        logic [COUNT_W-1:0] total;
    } slice_t;

    typedef struct packed {
        logic                time_only;
        logic                stall;
        logic                overdue;
        logic [MIN_BITS-1:0] elapsed_min;
        logic [MIN_BITS-1:0] stalled_min;
        logic [MIN_BITS-1:0] predicted_min;
        logic [PCT_BITS-1:0] pct;
    } wd_result_t;

    typedef struct packed {
        slice_t     stim;
        logic       typed;
        wd_result_t want;
    } directed_row_t;

    localparam directed_row_t DIRECTED_SLICES [23] = '{
        '{'{1'b1, 0, 1'b0, 0, 0}, 1'b1, '{0, 0, 0, 0, 0, 0, 0}},
        '{'{1'b0, 900000, 1'b0, 0, 0}, 1'b1, '{1, 0, 0, 15, 0, 0, 0}},
        '{'{1'b0, 2699999, 1'b0, 0, 0}, 1'b1, '{0, 0, 0, 44, 0, 0, 0}},
        '{'{1'b0, T_MAX, 1'b0, 0, 0}, 1'b1, '{1, 0, 0, 18325193, 0, 0, 0}},
        '{'{1'b0, T_MAX, 1'b0, 0, 0}, 1'b1, '{1, 0, 0, 18325193, 0, 0, 0}},
        '{'{1'b1, 0, 1'b1, 5, 0}, 1'b1, '{0, 0, 0, 0, 0, 0, 0}},
        '{'{1'b0, 60000, 1'b1, 10, 100}, 1'b1, '{0, 0, 0, 1, 0, 0, 100}},
        '{'{1'b0, 360000, 1'b1, 20, 100}, 1'b1, '{0, 0, 0, 6, 0, 46, 200}},
        '{'{1'b0, 2160000, 1'b1, 20, 100}, 1'b1, '{0, 1, 0, 36, 30, 46, 200}},
        '{'{1'b0, 6360000, 1'b1, 20, 100}, 1'b1, '{0, 1, 1, 106, 100, 46, 200}},
        '{'{1'b0, 9959999, 1'b1, 20, 100}, 1'b0, '0},
        '{'{1'b0, 9960000, 1'b1, 21, 100}, 1'b0, '0},
        '{'{1'b0, 10000000, 1'b1, 5, 100}, 1'b0, '0},
        '{'{1'b0, 10020000, 1'b0, 6, 100}, 1'b0, '0},
        '{'{1'b0, 10080000, 1'b1, C_MAX, 1}, 1'b1, '{0, 0, 0, 168, 0, 0, 65535}},
        '{'{1'b0, 10400000, 1'b1, C_MAX, 1}, 1'b0, '0},
        '{'{1'b0, 0, 1'b1, C_MAX, C_MAX}, 1'b0, '0},
        '{'{1'b1, T_MAX, 1'b1, C_MAX, C_MAX}, 1'b0, '0},
        '{'{1'b0, T_MAX, 1'b1, 0, C_MAX}, 1'b0, '0},
        '{'{1'b1, 0, 1'b1, 0, C_MAX}, 1'b0, '0},
        '{'{1'b0, 300000, 1'b1, 1, C_MAX}, 1'b0, '0},
        '{'{1'b0, T_MAX, 1'b1, 1, C_MAX}, 1'b0, '0},
        '{'{1'b0, T_MAX, 1'b0, C_MAX, C_MAX}, 1'b0, '0}
    };

    localparam cfg_mode_t PHASE_PLAN [6] = '{
        SET_ZERO, SET_MAX, SET_SMALL, SET_RANDOM, SET_SMALL, SET_DEFAULT
    };

    logic                clk;
    logic                rst_n = 1'b0;
    logic                cfg_we = 1'b0;
    logic [CFG_IDX_BITS-1:0] cfg_index = '0;
    logic [CFG_BITS-1:0] cfg_data = '0;
    logic                in_valid = 1'b0;
    logic                in_stall;
    logic                new_wait = 1'b0;
    logic [TIME_W-1:0]   elapsed_ms = '0;
    logic                probe_valid = 1'b0;
    logic [COUNT_W-1:0]  done_count = '0;
    logic [COUNT_W-1:0]  total_count = '0;
    logic                out_valid;
    logic                out_stall = 1'b0;
    logic                time_only_note;
    logic                stall_note;
    logic                overdue_note;
    logic [MIN_BITS-1:0] elapsed_minutes;
    logic [MIN_BITS-1:0] stalled_minutes;
    logic [MIN_BITS-1:0] predicted_minutes;
    logic [PCT_BITS-1:0] percent_tenths;

    logic steady = 1'b0;
    int   cycle_count = 0;
    int   mismatch_count = 0;
    wd_result_t pending_results [$];

    // register copies and tracking state of the watchdog
    logic [CFG_BITS-1:0] first_note_set, repeat_note_set, eta_window_set;
    logic [CFG_BITS-1:0] overdue_slack_set, overdue_repeat_set, stall_limit_set;
    logic                seen_progress;
    logic [COUNT_W-1:0]  base_done, prev_done;
    logic [TIME_W-1:0]   base_time, last_move_at, predicted_total_ms;
    logic [TIME_W-1:0]   next_overdue_at, next_stall_at, next_note_at;

    progress_aware_wait_watchdog_unit #(
        .TIME_BITS  (TIME_W),
        .COUNT_BITS (COUNT_W)
    ) DUT (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_we            (cfg_we),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .in_valid          (in_valid),
        .in_stall          (in_stall),
        .new_wait          (new_wait),
        .elapsed_ms        (elapsed_ms),
        .probe_valid       (probe_valid),
        .done_count        (done_count),
        .total_count       (total_count),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .time_only_note    (time_only_note),
        .stall_note        (stall_note),
        .overdue_note      (overdue_note),
        .elapsed_minutes   (elapsed_minutes),
        .stalled_minutes   (stalled_minutes),
        .predicted_minutes (predicted_minutes),
        .percent_tenths    (percent_tenths)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic logic [TIME_W-1:0] time_sat_add(input logic [63:0] a, input logic [63:0] b);
        logic [63:0] s;
        s = a + b;
        if (s < a || s > TIME_CEIL)
        begin
            return TIME_CEIL[TIME_W-1:0];
        end
        return s[TIME_W-1:0];
    endfunction

    // floor(a*b/d) over the full product, saturated to 64 bits
    function automatic logic [63:0] scaled_quotient(input logic [63:0] a, input logic [63:0] b,
                                                    input logic [63:0] d);
        logic [127:0] q;
        q = ({64'd0, a} * {64'd0, b}) / {64'd0, d};
        return (q[127:64] != 0) ? '1 : q[63:0];
    endfunction

    function automatic logic [MIN_BITS-1:0] to_minutes(input logic [63:0] ms);
        logic [63:0] m;
        m = ms / MIN_MS;
        return (m > 64'(MIN_CEIL)) ? MIN_CEIL : m[MIN_BITS-1:0];
    endfunction

    function automatic logic [63:0] rand40();
        logic [63:0] r;
        r = {$urandom, $urandom};
        return {24'd0, r[39:0]};
    endfunction

    function automatic void clear_tracking();
        seen_progress = 1'b0;
        base_done = '0;
        base_time = '0;
        prev_done = '0;
        last_move_at = '0;
        predicted_total_ms = '0;
        next_overdue_at = '0;
        next_stall_at = stall_limit_set;
        next_note_at = first_note_set;
    endfunction

    function automatic wd_result_t watchdog_forecast(input slice_t s);
        wd_result_t r;
        logic [63:0] elapsed, done, total, still, span, remaining, q;
        logic        probed;
        elapsed = 64'(s.elapsed);
        done = 64'(s.done);
        total = 64'(s.total);
        probed = s.probe && total != 0;
        r = '0;
        if (s.new_wait)
        begin
            clear_tracking();
        end
        if (!probed)
        begin
            if (elapsed >= next_note_at)
            begin
                r.time_only = 1'b1;
                next_note_at = time_sat_add(elapsed, repeat_note_set);
            end
        end
        else
        begin
            // first progress or progress going backwards restarts the measurement
            if (!seen_progress || done < prev_done)
            begin
                seen_progress = 1'b1;
                base_done = done[COUNT_W-1:0];
                base_time = elapsed[TIME_W-1:0];
                last_move_at = elapsed[TIME_W-1:0];
                predicted_total_ms = '0;
                next_overdue_at = '0;
            end
            else if (done > prev_done)
            begin
                last_move_at = elapsed[TIME_W-1:0];
            end
            prev_done = done[COUNT_W-1:0];

            q = scaled_quotient(done, 64'(PCT_SCALE), total);
            r.pct = (q > 64'(PCT_CEIL)) ? PCT_CEIL : q[PCT_BITS-1:0];

            still = (elapsed >= last_move_at) ? elapsed - last_move_at : 64'd0;
            r.stalled_min = to_minutes(still);
            if (still >= stall_limit_set && elapsed >= next_stall_at)
            begin
                r.stall = 1'b1;
                next_stall_at = time_sat_add(elapsed, stall_limit_set);
            end

            span = (elapsed >= base_time) ? elapsed - base_time : 64'd0;
            if (predicted_total_ms == 0 && span >= eta_window_set && done > base_done)
            begin
                remaining = 0;
                if (total > done && span != 0)
                begin
                    remaining = scaled_quotient(total - done, span, done - base_done);
                end
                if (remaining > TIME_CEIL)
                begin
                    remaining = TIME_CEIL;
                end
                predicted_total_ms = time_sat_add(elapsed, remaining);
            end

            if (predicted_total_ms != 0 &&
                elapsed >= time_sat_add(predicted_total_ms, overdue_slack_set) &&
                (next_overdue_at == 0 || elapsed >= next_overdue_at))
            begin
                r.overdue = 1'b1;
                next_overdue_at = time_sat_add(elapsed, overdue_repeat_set);
            end
        end
        r.elapsed_min = to_minutes(elapsed);
        r.predicted_min = to_minutes(64'(predicted_total_ms));
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
        begin
            $display("mismatch at cycle %0d: %s got %0d expected %0d", cycle_count, what, got,
                     want);
        end
    endtask

    task automatic check_result(input wd_result_t got);
        wd_result_t want;
        if (pending_results.size() == 0)
        begin
            report_mismatch("result transaction with nothing pending", 0, 0);
            return;
        end
        want = pending_results.pop_front();
        if (got.time_only != want.time_only)
            report_mismatch("time_only_note", got.time_only, want.time_only);
        if (got.stall != want.stall)
            report_mismatch("stall_note", got.stall, want.stall);
        if (got.overdue != want.overdue)
            report_mismatch("overdue_note", got.overdue, want.overdue);
        if (got.elapsed_min != want.elapsed_min)
            report_mismatch("elapsed_minutes", got.elapsed_min, want.elapsed_min);
        if (got.stalled_min != want.stalled_min)
            report_mismatch("stalled_minutes", got.stalled_min, want.stalled_min);
        if (got.predicted_min != want.predicted_min)
            report_mismatch("predicted_minutes", got.predicted_min, want.predicted_min);
        if (got.pct != want.pct)
            report_mismatch("percent_tenths", got.pct, want.pct);
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            check_result({time_only_note, stall_note, overdue_note, elapsed_minutes,
                          stalled_minutes, predicted_minutes, percent_tenths});
        end
    end

    always @(posedge clk)
    begin
        out_stall <= !steady && ($urandom_range(0, 99) < IDLE_PCT);
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    task automatic send_slice(input slice_t s, input logic typed, input wd_result_t want);
        wd_result_t forecast;
        while (!steady && $urandom_range(0, 99) < IDLE_PCT)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        new_wait <= s.new_wait;
        elapsed_ms <= s.elapsed;
        probe_valid <= s.probe;
        done_count <= s.done;
        total_count <= s.total;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
        forecast = watchdog_forecast(s);
        pending_results.push_back(typed ? want : forecast);
    endtask

    task automatic write_reg(input cfg_idx_t idx, input logic [CFG_BITS-1:0] value);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        case (idx)
            CFG_FIRST_NOTE:     first_note_set = value;
            CFG_REPEAT_NOTE:    repeat_note_set = value;
            CFG_ETA_SAMPLE:     eta_window_set = value;
            CFG_OVERDUE_SLACK:  overdue_slack_set = value;
            CFG_OVERDUE_REPEAT: overdue_repeat_set = value;
            CFG_STALL:          stall_limit_set = value;
            default:            ;
        endcase
    endtask

    function automatic logic [CFG_BITS-1:0] cfg_value(input cfg_mode_t mode,
                                                      input logic [CFG_BITS-1:0] dflt);
        case (mode)
            SET_ZERO:   return '0;
            SET_MAX:    return '1;
            SET_SMALL:  return $urandom_range(0, 2000000);
            SET_RANDOM: return $urandom;
            default:    return dflt;
        endcase
    endfunction

    task automatic program_phase(input cfg_mode_t mode);
        write_reg(CFG_FIRST_NOTE, cfg_value(mode, FIRST_NOTE_RST));
        write_reg(CFG_REPEAT_NOTE, cfg_value(mode, REPEAT_NOTE_RST));
        write_reg(CFG_ETA_SAMPLE, cfg_value(mode, ETA_SAMPLE_RST));
        write_reg(CFG_OVERDUE_SLACK, cfg_value(mode, OVERDUE_SLACK_RST));
        write_reg(CFG_OVERDUE_REPEAT, cfg_value(mode, OVERDUE_REPEAT_RST));
        write_reg(CFG_STALL, cfg_value(mode, STALL_RST));
        cfg_we <= 1'b0;
    endtask

    // mostly whole waits with moving time and progress, some raw noise
    task automatic run_waits(input int budget);
        slice_t            s;
        int                left, wait_len, pace, stuck_pct;
        logic [TIME_W-1:0] t;
        logic [COUNT_W-1:0] done, total;
        left = budget;
        while (left > 0)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                s.new_wait = ($urandom_range(0, 3) == 0);
                s.elapsed = rand40();
                s.probe = ($urandom_range(0, 1) == 1);
                s.done = rand40();
                s.total = ($urandom_range(0, 7) == 0) ? '0 : rand40();
                send_slice(s, 1'b0, '0);
                left--;
            end
            else
            begin
                wait_len = $urandom_range(5, 50);
                pace = $urandom_range(0, 3);
                stuck_pct = $urandom_range(10, 80);
                case ($urandom_range(0, 7))
                    0, 1, 2: total = $urandom_range(1, 1000);
                    3, 4, 5: total = $urandom_range(1000, 1000000000);
                    6:       total = rand40();
                    default: total = '0;
                endcase
                t = ($urandom_range(0, 3) == 0) ? rand40() >> $urandom_range(0, 39) : '0;
                done = ($urandom_range(0, 1) == 0) ? '0 : total >> $urandom_range(1, 10);
                for (int k = 0; k < wait_len && left > 0; k++)
                begin
                    s.new_wait = (k == 0);
                    s.elapsed = t;
                    s.probe = ($urandom_range(0, 19) != 0);
                    s.done = done;
                    s.total = total;
                    send_slice(s, 1'b0, '0);
                    left--;
                    case (pace)
                        0:       t = t + $urandom_range(0, 3);
                        1:       t = t + $urandom_range(0, 120000);
                        2:       t = t + $urandom_range(0, 3000000);
                        default: t = t + $urandom_range(0, 200000000);
                    endcase
                    if ($urandom_range(0, 29) == 0)
                    begin
                        t = t - $urandom_range(0, 200000);
                    end
                    if ($urandom_range(0, 24) == 0)
                    begin
                        done = done >> $urandom_range(1, 8);
                    end
                    else if ($urandom_range(0, 99) >= stuck_pct)
                    begin
                        done = done + (rand40() >> $urandom_range(20, 39));
                    end
                end
            end
        end
    endtask

    initial
    begin
        rst_n <= 1'b0;
        first_note_set = FIRST_NOTE_RST;
        repeat_note_set = REPEAT_NOTE_RST;
        eta_window_set = ETA_SAMPLE_RST;
        overdue_slack_set = OVERDUE_SLACK_RST;
        overdue_repeat_set = OVERDUE_REPEAT_RST;
        stall_limit_set = STALL_RST;
        clear_tracking();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (DIRECTED_SLICES[i])
        begin
            send_slice(DIRECTED_SLICES[i].stim, DIRECTED_SLICES[i].typed,
                       DIRECTED_SLICES[i].want);
        end

        foreach (PHASE_PLAN[p])
        begin
            // hold off until every pending transaction has come back
            in_valid <= 1'b0;
            while (pending_results.size() != 0)
            begin
                @(posedge clk);
            end
            program_phase(PHASE_PLAN[p]);
            steady <= (PHASE_PLAN[p] == SET_RANDOM);
            run_waits(ITEMS_PER_PHASE);
        end

        in_valid <= 1'b0;
        while (pending_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (pending_results.size() != 0)
        begin
            report_mismatch("results never produced", pending_results.size(), 0);
        end
        if (mismatch_count == 0)
        begin
            $display("TEST PASSED");
        end
        else
        begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

@@ files.f @@
hw/rtl/pawwd_pkg.sv
hw/rtl/pawwd_minutes.sv
hw/rtl/pawwd_muldiv.sv
hw/rtl/progress_aware_wait_watchdog_unit.sv
dv/progress_aware_wait_watchdog_unit_tb.sv
